// ----- sv/slis_pkg.sv -----
// shared constants, codes and controller/datapath types for the sorted list
`default_nettype none
package slis_pkg;

	// list geometry
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// port field widths
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int ST_W    = 3;
	localparam int COUNT_W = 7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

	// read address select, relative to the index register
	localparam logic [2:0] RD_NONE = 3'd0;
	localparam logic [2:0] RD_IDX  = 3'd1;
	localparam logic [2:0] RD_M1   = 3'd2;
	localparam logic [2:0] RD_M2   = 3'd3;
	localparam logic [2:0] RD_P1   = 3'd4;
	localparam logic [2:0] RD_P2   = 3'd5;

	// write data select
	localparam logic [1:0] WR_NONE = 2'd0;
	localparam logic [1:0] WR_KEY  = 2'd1;
	localparam logic [1:0] WR_RD   = 2'd2;

	// counter and index update
	localparam logic [1:0] UPD_HOLD = 2'd0;
	localparam logic [1:0] UPD_INC  = 2'd1;
	localparam logic [1:0] UPD_DEC  = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic            load;
		logic [ST_W-1:0] st_code;
		logic            st_load;
		logic [2:0]      rd_sel;
		logic [1:0]      wr_sel;
		logic [1:0]      idx_upd;
		logic [1:0]      cnt_upd;
		logic            push;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic pos_bad;
		logic idx_zero;
		logic idx_one;
		logic ge;
		logic eq;
		logic p1_last;
		logic p2_last;
		logic out_free;
	} dp_stat_t;

	// sign-extend or truncate a port value to the stored width
	function automatic logic [DATA_WIDTH-1:0] to_key(input logic [VALUE_W-1:0] v);
		logic [DATA_WIDTH-1:0] k;
		for (int b = 0; b < DATA_WIDTH; b++) begin
			k[b] = v[(b < VALUE_W) ? b : VALUE_W - 1];
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ----- sv/slis_if.sv -----
// request and response channel interfaces
`default_nettype none
interface slis_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] value;
	logic [6:0]  position;

	modport source (output valid, input ready, output cmd, output value, output position);
	modport sink   (input valid, output ready, input cmd, input value, input position);
endinterface

interface slis_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [6:0] count;

	modport source (output valid, input ready, output status, output count);
	modport sink   (input valid, output ready, input status, input count);
endinterface
`default_nettype wire

// ----- sv/slis_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module slis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- sv/slis_datapath.sv -----
// entry store, index and count registers, compare logic and result register
`default_nettype none
module slis_datapath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [1:0]             req_cmd,
	input  wire logic [31:0]            req_value,
	input  wire logic [6:0]             req_position,
	input  wire logic                   rsp_ready,
	output      logic                   rsp_valid,
	output      logic [2:0]             rsp_status,
	output      logic [6:0]             rsp_count,
	input  wire slis_pkg::dp_cmd_t      cmd,
	output      slis_pkg::dp_stat_t     stat
);
	import slis_pkg::*;

	logic [DATA_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ST_W-1:0]       status_q;
	logic                  out_valid_q;
	logic [ST_W-1:0]       out_status_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic                  ram_we;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// read address relative to the index
	always_comb begin
		ram_re    = 1'b1;
		ram_raddr = ADDR_W'(idx_q);
		case (cmd.rd_sel)
			RD_IDX:  ram_raddr = ADDR_W'(idx_q);
			RD_M1:   ram_raddr = ADDR_W'(idx_q - CNT_W'(1));
			RD_M2:   ram_raddr = ADDR_W'(idx_q - CNT_W'(2));
			RD_P1:   ram_raddr = ADDR_W'(idx_q + CNT_W'(1));
			RD_P2:   ram_raddr = ADDR_W'(idx_q + CNT_W'(2));
			default: ram_re    = 1'b0;
		endcase
	end

	// write at the index, either the new key or the entry just read
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = key_q;
		case (cmd.wr_sel)
			WR_KEY: begin
				ram_we    = 1'b1;
				ram_wdata = key_q;
			end
			WR_RD: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: ram_we = 1'b0;
		endcase
	end

	slis_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ADDR_W'(idx_q)),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// key, index and status registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= to_key(req_value);
			case (req_cmd)
				CMD_INSERT: idx_q <= cnt_q;
				CMD_REMOVE: idx_q <= CNT_W'(req_position - POS_W'(1));
				default:    idx_q <= '0;
			endcase
		end else begin
			case (cmd.idx_upd)
				UPD_INC: idx_q <= idx_q + CNT_W'(1);
				UPD_DEC: idx_q <= idx_q - CNT_W'(1);
				default: idx_q <= idx_q;
			endcase
		end
		if (cmd.st_load) begin
			status_q <= cmd.st_code;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.cnt_upd)
				UPD_INC: cnt_q <= cnt_q + CNT_W'(1);
				UPD_DEC: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= status_q;
			out_count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_count  = out_count_q;

	// status flags for the controller
	always_comb begin
		stat.cnt_zero = (cnt_q == '0);
		stat.cnt_full = (cnt_q >= CNT_W'(DEPTH));
		stat.pos_bad  = (req_position == '0) || (int'(req_position) > int'(cnt_q));
		stat.idx_zero = (idx_q == '0);
		stat.idx_one  = (idx_q == CNT_W'(1));
		stat.ge       = ($signed(ram_rdata) >= $signed(key_q));
		stat.eq       = (ram_rdata == key_q);
		stat.p1_last  = (CNT_W'(idx_q + CNT_W'(1)) == cnt_q);
		stat.p2_last  = (CNT_W'(idx_q + CNT_W'(2)) == cnt_q);
		stat.out_free = !out_valid_q || rsp_ready;
	end

`ifndef ASSERT_OFF
	// count never passes the list depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// count moves by at most one per cycle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |->
			(cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)) ||
			 cnt_q == CNT_W'($past(cnt_q) - CNT_W'(1))))
		else $error("entry count jumped");

	// a new result never overwrites one that is still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || rsp_ready))
		else $error("result overwritten");

	// writes stay inside the RAM depth
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> idx_q < CNT_W'(DEPTH))
		else $error("write outside list");
`endif
endmodule
`default_nettype wire

// ----- sv/slis_ctrl.sv -----
// command sequencer for insert, search and remove
`default_nettype none
module slis_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic [1:0]         req_cmd,
	output      logic               req_ready,
	input  wire slis_pkg::dp_stat_t stat,
	output      slis_pkg::dp_cmd_t  cmd
);
	import slis_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS_RD   = 3'd1;
	localparam logic [2:0] S_INS_CMP  = 3'd2;
	localparam logic [2:0] S_SRCH_RD  = 3'd3;
	localparam logic [2:0] S_SRCH_CMP = 3'd4;
	localparam logic [2:0] S_REM_RD   = 3'd5;
	localparam logic [2:0] S_REM_MV   = 3'd6;
	localparam logic [2:0] S_FIN      = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and datapath commands
	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.load    = 1'b0;
		cmd.st_code = ST_OK;
		cmd.st_load = 1'b0;
		cmd.rd_sel  = RD_NONE;
		cmd.wr_sel  = WR_NONE;
		cmd.idx_upd = UPD_HOLD;
		cmd.cnt_upd = UPD_HOLD;
		cmd.push    = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load    = 1'b1;
					cmd.st_load = 1'b1;
					case (req_cmd)
						CMD_INSERT: begin
							if (stat.cnt_full) begin
								cmd.st_code = ST_FULL;
								state_d     = S_FIN;
							end else begin
								state_d = S_INS_RD;
							end
						end
						CMD_SEARCH: begin
							if (stat.cnt_zero) begin
								cmd.st_code = ST_NOT_FOUND;
								state_d     = S_FIN;
							end else begin
								state_d = S_SRCH_RD;
							end
						end
						CMD_REMOVE: begin
							if (stat.cnt_zero) begin
								cmd.st_code = ST_EMPTY;
								state_d     = S_FIN;
							end else if (stat.pos_bad) begin
								cmd.st_code = ST_BAD_POS;
								state_d     = S_FIN;
							end else begin
								state_d = S_REM_RD;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			// insert: walk down from the top, moving entries not smaller than the key
			S_INS_RD: begin
				if (stat.idx_zero) begin
					cmd.wr_sel  = WR_KEY;
					cmd.cnt_upd = UPD_INC;
					state_d     = S_FIN;
				end else begin
					cmd.rd_sel = RD_M1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (stat.ge) begin
					cmd.wr_sel  = WR_RD;
					cmd.idx_upd = UPD_DEC;
					if (stat.idx_one) begin
						state_d = S_INS_RD;
					end else begin
						cmd.rd_sel = RD_M2;
					end
				end else begin
					cmd.wr_sel  = WR_KEY;
					cmd.cnt_upd = UPD_INC;
					state_d     = S_FIN;
				end
			end
			// search: scan from the bottom until a match or the end
			S_SRCH_RD: begin
				cmd.rd_sel = RD_IDX;
				state_d    = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (stat.eq) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_OK;
					state_d     = S_FIN;
				end else if (stat.p1_last) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_NOT_FOUND;
					state_d     = S_FIN;
				end else begin
					cmd.rd_sel  = RD_P1;
					cmd.idx_upd = UPD_INC;
				end
			end
			// remove: pull the entries above the position down by one
			S_REM_RD: begin
				if (stat.p1_last) begin
					cmd.cnt_upd = UPD_DEC;
					state_d     = S_FIN;
				end else begin
					cmd.rd_sel = RD_P1;
					state_d    = S_REM_MV;
				end
			end
			S_REM_MV: begin
				cmd.wr_sel  = WR_RD;
				cmd.idx_upd = UPD_INC;
				if (stat.p2_last) begin
					cmd.cnt_upd = UPD_DEC;
					state_d     = S_FIN;
				end else begin
					cmd.rd_sel = RD_P2;
				end
			end
			// hand the word to the result register once it is free
			S_FIN: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ----- sv/sorted_list_insert_search_remove.sv -----
// top level of the sorted list: sequencer plus datapath
// Keeps up to 64 signed 32-bit values in ascending order in a single-port-read,
// single-port-write RAM. One command word is taken at a time on req and one
// result word (status and new count) is returned on rsp. Insert moves up the
// entries not smaller than the value, search scans from the bottom until a
// match or the end, remove pulls the entries above the position down, and
// rejected or unknown commands go straight to the result. A finished word waits
// while the output register still holds an unread word. The next command is
// taken in the cycle after the result is loaded into the output register, even
// if that word has not yet been read. No clearing pass is needed after reset.
`default_nettype none
module sorted_list_insert_search_remove (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slis_req_if.sink   req,
	slis_rsp_if.source rsp
);
	import slis_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     req_ready;

	assign req.ready = req_ready;

	// sequencer
	slis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_cmd  (req.cmd),
		.req_ready(req_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// storage and compare
	slis_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_cmd     (req.cmd),
		.req_value   (req.value),
		.req_position(req.position),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_status  (rsp.status),
		.rsp_count   (rsp.count),
		.cmd         (dp_cmd),
		.stat        (dp_stat)
	);
endmodule
`default_nettype wire
